// ===== hdl/bsmic_pkg.sv =====
// shared types and constants for the bank switch mapper with irq counter
package bsmic_pkg;

	typedef enum logic [2:0] {
		FUNC_CPU_RD = 3'd0,
		FUNC_CPU_WR = 3'd1,
		FUNC_PPU_RD = 3'd2,
		FUNC_PPU_WR = 3'd3,
		FUNC_TICK   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_PRG  = 2'd1,
		TGT_RAM  = 2'd2,
		TGT_CHR  = 2'd3
	} target_t;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [1:0] CFG_IRQ_FIRE  = 2'd2;

	// mapper commands
	localparam logic [3:0] CMD_PRG0     = 4'h8;
	localparam logic [3:0] CMD_MIRROR   = 4'hC;
	localparam logic [3:0] CMD_IRQ_CTRL = 4'hD;
	localparam logic [3:0] CMD_CNT_LO   = 4'hE;
	localparam logic [3:0] CMD_CNT_HI   = 4'hF;

	// cpu address windows, top three address bits
	localparam logic [2:0] WIN_RAM   = 3'b011;
	localparam logic [2:0] WIN_CMD   = 3'b100;
	localparam logic [2:0] WIN_PARAM = 3'b101;
	localparam logic [2:0] WIN_CHR   = 3'b000;

	localparam int          CFG_W          = 16;
	localparam int          COUNT_W        = 9;
	localparam int          BANK_W         = 8;
	localparam int          MADDR_W        = 21;
	localparam logic [8:0]  PRG_COUNT_RST  = 9'd32;
	localparam logic [8:0]  CHR_COUNT_RST  = 9'd256;
	localparam logic [15:0] IRQ_FIRE_RST   = 16'hFFF8;
	localparam logic [1:0]  TICK_PHASE_MAX = 2'd2;

	// reset contents of the prg bank slots: 0, count-4, count-3, count-2
	localparam logic [7:0] PRG_BANK1_RST = 8'(PRG_COUNT_RST - 9'd4);
	localparam logic [7:0] PRG_BANK2_RST = 8'(PRG_COUNT_RST - 9'd3);
	localparam logic [7:0] PRG_BANK3_RST = 8'(PRG_COUNT_RST - 9'd2);

	// bank mask: count minus one, low eight bits
	function automatic logic [7:0] count_mask(input logic [8:0] count);
		logic [8:0] m;
		m = count - 9'd1;
		return m[7:0];
	endfunction

endpackage

// ===== hdl/bank_switch_mapper_irq_counter_core.sv =====
// top level of the bank switch mapper with irq counter
//
// usage
// - input channel (in_valid / in_stall) carries one bus access or system tick per
//   transfer: func, bus_address, bus_data
// - output channel (out_valid / out_stall) returns exactly one result per input
//   transfer: target, mapped_address, write_enable, write_data, irq_line,
//   mirror_mode (irq and mirroring as they stand after that item)
// - items flow through an input register (_s1) and a result register; the
//   decode and all register updates for an item happen as it moves from the
//   input register into the result register
// - throughput: one item per cycle while out_stall is low, limited only by the
//   single decode stage between the two registers
// - a stall on the output holds the result register; once the input register
//   also holds an item, in_stall follows out_stall, so nothing is lost or repeated
// - configuration port: cfg_we writes cfg_data to register cfg_index at the
//   clock edge; the user writes only while idle (unenforced); index 3 is ignored
// - reset (arst_n low) empties both registers and returns mapper state to
//   its power-up values: chr banks 0..7, prg banks 0/28/29/30, irq off,
//   counts 32 and 256, fire value fff8
module bank_switch_mapper_irq_counter_core
	import bsmic_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           func,
	input  logic [15:0]          bus_address,
	input  logic [7:0]           bus_data,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           target,
	output logic [MADDR_W-1:0]   mapped_address,
	output logic                 write_enable,
	output logic [7:0]           write_data,
	output logic                 irq_line,
	output logic [1:0]           mirror_mode
);

	// configuration registers
	logic [COUNT_W-1:0] prg_count_q;
	logic [COUNT_W-1:0] chr_count_q;
	logic [15:0]        irq_fire_q;

	// mapper state
	logic [3:0]        command_q;
	logic [BANK_W-1:0] chr_bank_q [8];
	logic [BANK_W-1:0] prg_bank_q [4];
	logic              ram_sel_q;
	logic              ram_en_q;
	logic [1:0]        mirror_q;
	logic              irq_en_q;
	logic              cnt_en_q;
	logic [15:0]       irq_cnt_q;
	logic [1:0]        phase_q;
	logic              irq_pend_q;

	// input register
	logic        valid_s1;
	logic [2:0]  func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// result register
	logic               out_valid_q;
	target_t            target_q;
	logic [MADDR_W-1:0] maddr_q;
	logic               we_q;
	logic [7:0]         wdata_q;
	logic               irq_q;
	logic [1:0]         mirror_out_q;

	// handshake: the stage item moves on when the result register is free
	logic advance;
	logic load_s1;

	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	// decode results and next state for the item in the input register
	target_t            tgt_d;
	logic [MADDR_W-1:0] maddr_d;
	logic               we_d;
	logic [3:0]         command_d;
	logic [BANK_W-1:0]  chr_bank_d [8];
	logic [BANK_W-1:0]  prg_bank_d [4];
	logic               ram_sel_d;
	logic               ram_en_d;
	logic [1:0]         mirror_d;
	logic               irq_en_d;
	logic               cnt_en_d;
	logic [15:0]        irq_cnt_d;
	logic [1:0]         phase_d;
	logic               irq_pend_d;

	logic [2:0]        win3;
	logic [1:0]        rom_win;
	logic [7:0]        rom_bank;
	logic [7:0]        chr_mask;
	logic [7:0]        prg_mask;
	logic [15:0]       cnt_dec;

	assign win3     = addr_s1[15:13];
	assign rom_win  = addr_s1[14:13];
	assign chr_mask = count_mask(chr_count_q);
	assign prg_mask = count_mask(prg_count_q);
	assign cnt_dec  = irq_cnt_q - 16'd1;

	// rom windows 8000/a000/c000 use slots 1..3, e000 is fixed to the last bank
	always_comb begin
		case (rom_win)
			2'd0:    rom_bank = prg_bank_q[1];
			2'd1:    rom_bank = prg_bank_q[2];
			2'd2:    rom_bank = prg_bank_q[3];
			default: rom_bank = prg_mask;
		endcase
	end

	always_comb begin
		tgt_d      = TGT_NONE;
		maddr_d    = '0;
		we_d       = 1'b0;
		command_d  = command_q;
		chr_bank_d = chr_bank_q;
		prg_bank_d = prg_bank_q;
		ram_sel_d  = ram_sel_q;
		ram_en_d   = ram_en_q;
		mirror_d   = mirror_q;
		irq_en_d   = irq_en_q;
		cnt_en_d   = cnt_en_q;
		irq_cnt_d  = irq_cnt_q;
		phase_d    = phase_q;
		irq_pend_d = irq_pend_q;

		case (func_s1)
			FUNC_CPU_RD: begin
				if (win3 == WIN_RAM) begin
					if (!ram_sel_q) begin
						tgt_d   = TGT_PRG;
						maddr_d = {prg_bank_q[0], addr_s1[12:0]};
					end else if (ram_en_q) begin
						tgt_d   = TGT_RAM;
						maddr_d = {8'd0, addr_s1[12:0]};
					end
				end else if (addr_s1[15]) begin
					tgt_d   = TGT_PRG;
					maddr_d = {rom_bank, addr_s1[12:0]};
				end
			end
			FUNC_CPU_WR: begin
				if (win3 == WIN_RAM) begin
					if (ram_sel_q && ram_en_q) begin
						tgt_d   = TGT_RAM;
						maddr_d = {8'd0, addr_s1[12:0]};
						we_d    = 1'b1;
					end
				end else if (win3 == WIN_CMD) begin
					command_d = data_s1[3:0];
				end else if (win3 == WIN_PARAM) begin
					// parameter write, chosen by the latched command
					case (command_q) inside
						[4'h0:4'h7]: chr_bank_d[command_q[2:0]] = data_s1 & chr_mask;
						[4'h8:4'hB]: begin
							prg_bank_d[command_q[1:0]] = data_s1 & prg_mask;
							if (command_q == CMD_PRG0) begin
								ram_sel_d = data_s1[6];
								ram_en_d  = data_s1[7];
							end
						end
						CMD_MIRROR: begin
							if (!data_s1[2]) mirror_d = data_s1[1:0];
						end
						CMD_IRQ_CTRL: begin
							irq_en_d   = data_s1[0];
							cnt_en_d   = data_s1[7];
							irq_pend_d = 1'b0;
						end
						CMD_CNT_LO: irq_cnt_d = {irq_cnt_q[15:8], data_s1};
						CMD_CNT_HI: irq_cnt_d = {data_s1, irq_cnt_q[7:0]};
						default: ;
					endcase
				end
			end
			FUNC_PPU_RD, FUNC_PPU_WR: begin
				if (win3 == WIN_CHR) begin
					tgt_d   = TGT_CHR;
					maddr_d = {3'd0, chr_bank_q[addr_s1[12:10]], addr_s1[9:0]};
					we_d    = (func_s1 == FUNC_PPU_WR);
				end
			end
			FUNC_TICK: begin
				// counter steps on phase zero of every three ticks
				if (cnt_en_q && phase_q == 2'd0) begin
					irq_cnt_d = cnt_dec;
					if (cnt_dec == irq_fire_q && irq_en_q) irq_pend_d = 1'b1;
				end
				phase_d = (phase_q >= TICK_PHASE_MAX) ? 2'd0 : phase_q + 2'd1;
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= PRG_COUNT_RST;
			chr_count_q <= CHR_COUNT_RST;
			irq_fire_q  <= IRQ_FIRE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_COUNT: prg_count_q <= cfg_data[COUNT_W-1:0];
				CFG_CHR_COUNT: chr_count_q <= cfg_data[COUNT_W-1:0];
				CFG_IRQ_FIRE:  irq_fire_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// mapper state, updated as an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q <= '0;
			for (int i = 0; i < 8; i++) begin
				chr_bank_q[i] <= BANK_W'(i);
			end
			prg_bank_q[0] <= '0;
			prg_bank_q[1] <= PRG_BANK1_RST;
			prg_bank_q[2] <= PRG_BANK2_RST;
			prg_bank_q[3] <= PRG_BANK3_RST;
			ram_sel_q  <= 1'b0;
			ram_en_q   <= 1'b0;
			mirror_q   <= '0;
			irq_en_q   <= 1'b0;
			cnt_en_q   <= 1'b0;
			irq_cnt_q  <= '0;
			phase_q    <= '0;
			irq_pend_q <= 1'b0;
		end else if (advance) begin
			command_q  <= command_d;
			chr_bank_q <= chr_bank_d;
			prg_bank_q <= prg_bank_d;
			ram_sel_q  <= ram_sel_d;
			ram_en_q   <= ram_en_d;
			mirror_q   <= mirror_d;
			irq_en_q   <= irq_en_d;
			cnt_en_q   <= cnt_en_d;
			irq_cnt_q  <= irq_cnt_d;
			phase_q    <= phase_d;
			irq_pend_q <= irq_pend_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			func_s1 <= func;
			addr_s1 <= bus_address;
			data_s1 <= bus_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_q     <= tgt_d;
			maddr_q      <= maddr_d;
			we_q         <= we_d;
			wdata_q      <= we_d ? data_s1 : 8'd0;
			irq_q        <= irq_pend_d;
			mirror_out_q <= mirror_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign target         = target_q;
	assign mapped_address = maddr_q;
	assign write_enable   = we_q;
	assign write_data     = wdata_q;
	assign irq_line       = irq_q;
	assign mirror_mode    = mirror_out_q;

endmodule

// ===== verif/tb_top.sv =====
// testbench for the bank switch mapper: directed and random bus traffic checked against a predictor
module tb_top
	import bsmic_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// command ranges not named in the package
	localparam logic [3:0] CMD_CHR_LAST = 4'h7;
	localparam logic [3:0] CMD_PRG_LAST = 4'hB;

	localparam int RANDOM_PER_PHASE = 370;

	// one bus access or tick as it goes into the block
	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] addr;
		logic [7:0]  data;
	} access_t;

	// one mapping result as it comes out of the block
	typedef struct packed {
		target_t            tgt;
		logic [MADDR_W-1:0] maddr;
		logic               we;
		logic [7:0]         wdata;
		logic               irq;
		logic [1:0]         mirror;
	} mapping_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [1:0]           cfg_index = CFG_PRG_COUNT;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [2:0]           func = FUNC_CPU_RD;
	logic [15:0]          bus_address = '0;
	logic [7:0]           bus_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           target;
	logic [MADDR_W-1:0]   mapped_address;
	logic                 write_enable;
	logic [7:0]           write_data;
	logic                 irq_line;
	logic [1:0]           mirror_mode;

	bank_switch_mapper_irq_counter_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.bus_address    (bus_address),
		.bus_data       (bus_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target         (target),
		.mapped_address (mapped_address),
		.write_enable   (write_enable),
		.write_data     (write_data),
		.irq_line       (irq_line),
		.mirror_mode    (mirror_mode)
	);

	// accesses waiting to be driven, and mappings waiting to come out
	access_t  access_queue[$];
	mapping_t due_mappings[$];

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;

	// idling controls, changed per phase
	bit calm = 1'b0;
	int gap_pct = 15;
	int stall_pct = 15;
	int gap_left = 0;
	int stall_left = 0;
	bit in_took = 1'b0;

	// fire value as the stimulus side last programmed it, used to aim irq sequences
	logic [15:0] cur_fire = IRQ_FIRE_RST;

	// predictor copy of the configuration and mapper state
	logic [COUNT_W-1:0] m_prg_count;
	logic [COUNT_W-1:0] m_chr_count;
	logic [15:0]        m_fire;
	logic [3:0]         m_cmd;
	logic [7:0]         m_chr_bank[8];
	logic [7:0]         m_prg_bank[4];
	logic               m_ram_sel;
	logic               m_ram_en;
	logic [1:0]         m_mirror;
	logic               m_irq_en;
	logic               m_cnt_en;
	logic [15:0]        m_counter;
	logic [1:0]         m_phase;
	logic               m_irq_pend;

	access_t  next_access;
	mapping_t got_mapping;
	mapping_t want_mapping;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// decode one access against the predictor state and update that state
	function automatic mapping_t map_access(access_t it);
		mapping_t   r;
		logic [7:0] prg_mask;
		logic [7:0] chr_mask;
		logic [7:0] bank;
		r = '0;
		// masks are count minus one kept to eight bits, so a count of zero gives ff
		prg_mask = 8'(m_prg_count - 9'd1);
		chr_mask = 8'(m_chr_count - 9'd1);
		case (it.func)
			FUNC_CPU_RD: begin
				if (it.addr[15:13] == WIN_RAM) begin
					if (!m_ram_sel) begin
						r.tgt = TGT_PRG;
						r.maddr = {m_prg_bank[0], it.addr[12:0]};
					end else if (m_ram_en) begin
						r.tgt = TGT_RAM;
						r.maddr = MADDR_W'(it.addr[12:0]);
					end
					// ram selected but disabled reads as open bus
				end else if (it.addr[15]) begin
					// e000 window follows the current count, the others use the slots
					if (it.addr[14:13] == 2'b11)
						bank = prg_mask;
					else
						bank = m_prg_bank[it.addr[14:13] + 2'd1];
					r.tgt = TGT_PRG;
					r.maddr = {bank, it.addr[12:0]};
				end
			end
			FUNC_CPU_WR: begin
				case (it.addr[15:13])
					WIN_RAM: begin
						if (m_ram_sel && m_ram_en) begin
							r.tgt = TGT_RAM;
							r.maddr = MADDR_W'(it.addr[12:0]);
							r.we = 1'b1;
							r.wdata = it.data;
						end
					end
					WIN_CMD: m_cmd = it.data[3:0];
					WIN_PARAM: begin
						if (m_cmd <= CMD_CHR_LAST) begin
							m_chr_bank[m_cmd[2:0]] = it.data & chr_mask;
						end else if (m_cmd <= CMD_PRG_LAST) begin
							m_prg_bank[m_cmd[1:0]] = it.data & prg_mask;
							if (m_cmd == CMD_PRG0) begin
								m_ram_sel = it.data[6];
								m_ram_en = it.data[7];
							end
						end else if (m_cmd == CMD_MIRROR) begin
							// codes 4 to 7 leave the mirroring alone
							if (!it.data[2])
								m_mirror = it.data[1:0];
						end else if (m_cmd == CMD_IRQ_CTRL) begin
							m_irq_en = it.data[0];
							m_cnt_en = it.data[7];
							m_irq_pend = 1'b0;
						end else if (m_cmd == CMD_CNT_LO) begin
							m_counter[7:0] = it.data;
						end else begin
							m_counter[15:8] = it.data;
						end
					end
					default: ;
				endcase
			end
			FUNC_PPU_RD, FUNC_PPU_WR: begin
				if (it.addr[15:13] == WIN_CHR) begin
					r.tgt = TGT_CHR;
					r.maddr = MADDR_W'({m_chr_bank[it.addr[12:10]], it.addr[9:0]});
					r.we = (it.func == FUNC_PPU_WR);
					r.wdata = r.we ? it.data : 8'h00;
				end
			end
			FUNC_TICK: begin
				// counter steps on the tick seen at phase zero
				if (m_cnt_en && m_phase == 2'd0) begin
					m_counter = m_counter - 16'd1;
					if (m_counter == m_fire && m_irq_en)
						m_irq_pend = 1'b1;
				end
				m_phase = (m_phase >= TICK_PHASE_MAX) ? 2'd0 : m_phase + 2'd1;
			end
			default: ;
		endcase
		r.irq = m_irq_pend;
		r.mirror = m_mirror;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// monitor, predictor and register shadow all sample at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_mapping = '{target_t'(target), mapped_address, write_enable,
					write_data, irq_line, mirror_mode};
				if (due_mappings.size() == 0) begin
					$display("%0t: result transfer with nothing expected, actual %0h",
						$time, got_mapping);
					mismatches++;
				end else begin
					want_mapping = due_mappings.pop_front();
					check_field("target", 32'(want_mapping.tgt), 32'(got_mapping.tgt));
					check_field("mapped_address", 32'(want_mapping.maddr),
						32'(got_mapping.maddr));
					check_field("write_enable", 32'(want_mapping.we), 32'(got_mapping.we));
					check_field("write_data", 32'(want_mapping.wdata),
						32'(got_mapping.wdata));
					check_field("irq_line", 32'(want_mapping.irq), 32'(got_mapping.irq));
					check_field("mirror_mode", 32'(want_mapping.mirror),
						32'(got_mapping.mirror));
				end
			end
			in_took = in_valid && !in_stall;
			if (in_took) begin
				due_mappings.push_back(map_access('{func, bus_address, bus_data}));
				items_taken++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_COUNT: m_prg_count = cfg_data[COUNT_W-1:0];
					CFG_CHR_COUNT: m_chr_count = cfg_data[COUNT_W-1:0];
					CFG_IRQ_FIRE:  m_fire = cfg_data[15:0];
					default: ;
				endcase
			end
		end else begin
			in_took = 1'b0;
		end
	end

	// input driver: holds a stalled transfer, otherwise idles in bursts or sends the next access
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_took)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
				gap_left = $urandom_range(0, 6);
				in_valid <= 1'b0;
			end else if (access_queue.size() > 0) begin
				next_access = access_queue.pop_front();
				func <= next_access.func;
				bus_address <= next_access.addr;
				bus_data <= next_access.data;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side: stall in random bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_access(input logic [2:0] f, input logic [15:0] a, input logic [7:0] d);
		access_queue.push_back('{f, a, d});
		items_queued++;
	endtask

	// a command latch write followed by the parameter write it steers
	task automatic push_param(input logic [3:0] cmd, input logic [7:0] d);
		push_access(FUNC_CPU_WR, {WIN_CMD, 13'($urandom)}, {4'($urandom), cmd});
		push_access(FUNC_CPU_WR, {WIN_PARAM, 13'($urandom)}, d);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [8:0] prg, input logic [8:0] chr,
			input logic [15:0] fire);
		write_cfg(CFG_PRG_COUNT, CFG_W'(prg));
		write_cfg(CFG_CHR_COUNT, CFG_W'(chr));
		write_cfg(CFG_IRQ_FIRE, fire);
		cur_fire = fire;
	endtask

	// hold the sender until every access is taken and every mapping is back
	task automatic drain();
		while (items_taken != items_queued || due_mappings.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// random traffic, mostly well formed register sequences with random content
	task automatic add_random(input int n);
		int          made;
		int          queued_at_start;
		int          sel;
		int          k;
		logic [15:0] cnt;
		logic [7:0]  ctrl;
		made = 0;
		while (made < n) begin
			queued_at_start = items_queued;
			sel = $urandom_range(0, 99);
			if (sel < 20) begin
				push_param(4'($urandom_range(0, 15)), pick_byte());
			end else if (sel < 32) begin
				// ram select and enable, then traffic in the 6000 window
				push_param(CMD_PRG0, {($urandom_range(0, 3) != 0) ? 2'b11 : 2'($urandom),
					6'($urandom)});
				repeat ($urandom_range(2, 5))
					push_access($urandom_range(0, 1) ? FUNC_CPU_WR : FUNC_CPU_RD,
						{WIN_RAM, 13'($urandom)}, pick_byte());
			end else if (sel < 44) begin
				// load the counter at or just above the fire value, enable, then tick through it
				k = $urandom_range(0, 5);
				cnt = cur_fire + 16'(k);
				ctrl = {($urandom_range(0, 9) != 0) ? 1'b1 : 1'b0, 6'($urandom),
					($urandom_range(0, 4) != 0) ? 1'b1 : 1'b0};
				push_param(CMD_CNT_LO, cnt[7:0]);
				push_param(CMD_CNT_HI, cnt[15:8]);
				push_param(CMD_IRQ_CTRL, ctrl);
				repeat ($urandom_range(1, 3 * k + 4))
					push_access(FUNC_TICK, 16'($urandom), 8'($urandom));
			end else if (sel < 54) begin
				push_param(4'($urandom_range(0, 7)), pick_byte());
				repeat ($urandom_range(1, 4))
					push_access($urandom_range(0, 1) ? FUNC_PPU_WR : FUNC_PPU_RD,
						{WIN_CHR, 13'($urandom)}, pick_byte());
			end else if (sel < 72) begin
				push_access(FUNC_CPU_RD, 16'($urandom), 8'($urandom));
			end else if (sel < 86) begin
				push_access($urandom_range(0, 1) ? FUNC_PPU_WR : FUNC_PPU_RD,
					($urandom_range(0, 4) != 0) ? {WIN_CHR, 13'($urandom)} : 16'($urandom),
					pick_byte());
			end else if (sel < 94) begin
				repeat ($urandom_range(1, 12))
					push_access(FUNC_TICK, 16'($urandom), 8'($urandom));
			end else if (sel < 97) begin
				push_access(FUNC_CPU_WR, 16'($urandom), pick_byte());
			end else begin
				// unused function codes, ignored by the block
				push_access(3'($urandom_range(5, 7)), 16'($urandom), 8'($urandom));
			end
			if (sel < 97)
				made += items_queued - queued_at_start;
		end
	endtask

	initial begin
		logic [15:0] cnt;
		// predictor starts from the power-up state
		m_prg_count = PRG_COUNT_RST;
		m_chr_count = CHR_COUNT_RST;
		m_fire = IRQ_FIRE_RST;
		m_cmd = '0;
		for (int i = 0; i < 8; i++)
			m_chr_bank[i] = 8'(i);
		m_prg_bank[0] = 8'h00;
		m_prg_bank[1] = 8'(PRG_COUNT_RST - 9'd4);
		m_prg_bank[2] = 8'(PRG_COUNT_RST - 9'd3);
		m_prg_bank[3] = 8'(PRG_COUNT_RST - 9'd2);
		m_ram_sel = 1'b0;
		m_ram_en = 1'b0;
		m_mirror = 2'd0;
		m_irq_en = 1'b0;
		m_cnt_en = 1'b0;
		m_counter = '0;
		m_phase = '0;
		m_irq_pend = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part under the power-up configuration
		push_access(FUNC_CPU_RD, 16'h5FFF, 8'h00);
		push_access(FUNC_CPU_RD, 16'h6000, 8'h00);
		push_access(FUNC_CPU_RD, 16'h8000, 8'h00);
		push_access(FUNC_CPU_RD, 16'hA000, 8'h00);
		push_access(FUNC_CPU_RD, 16'hC000, 8'h00);
		push_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
		push_access(FUNC_PPU_RD, 16'h1FFF, 8'h00);
		push_access(FUNC_PPU_RD, 16'h2000, 8'h00);
		push_access(FUNC_PPU_WR, 16'h0000, 8'hFF);
		push_access(3'd7, 16'hFFFF, 8'hFF);
		// ram selected but disabled reads as open bus, then enabled it takes a write
		push_param(CMD_PRG0, 8'h40);
		push_access(FUNC_CPU_RD, 16'h6000, 8'h00);
		push_param(CMD_PRG0, 8'hC0);
		push_access(FUNC_CPU_WR, 16'h7FFF, 8'hFF);
		// mirroring code out of range keeps the old setting
		push_param(CMD_MIRROR, 8'h07);
		// counter one above the fire value fires on the first tick, control write clears it
		cnt = IRQ_FIRE_RST + 16'd1;
		push_param(CMD_CNT_LO, cnt[7:0]);
		push_param(CMD_CNT_HI, cnt[15:8]);
		push_param(CMD_IRQ_CTRL, 8'h81);
		push_access(FUNC_TICK, 16'h0000, 8'h00);
		push_param(CMD_IRQ_CTRL, 8'h00);
		drain();

		// smallest counts and fire value
		gap_pct = 20;
		stall_pct = 20;
		set_config(9'd4, 9'd8, 16'h0000);
		add_random(RANDOM_PER_PHASE);
		drain();

		// largest counts and fire value
		gap_pct = 40;
		stall_pct = 10;
		set_config(9'd256, 9'd256, 16'hFFFF);
		add_random(RANDOM_PER_PHASE);
		drain();

		// zero counts mask with ff
		gap_pct = 5;
		stall_pct = 40;
		set_config(9'd0, 9'd0, 16'($urandom));
		add_random(RANDOM_PER_PHASE);
		drain();

		// random counts, often not powers of two, mask with their count minus one
		gap_pct = 25;
		stall_pct = 25;
		set_config(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), 16'($urandom));
		add_random(RANDOM_PER_PHASE);
		drain();

		// back to legal counts, full rate on both sides
		calm = 1'b1;
		set_config(9'd1 << $urandom_range(2, 8), 9'd1 << $urandom_range(3, 8), 16'($urandom));
		add_random(RANDOM_PER_PHASE);
		drain();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bsmic_pkg.sv
hdl/bank_switch_mapper_irq_counter_core.sv
verif/tb_top.sv
